FILE: rtl/core/bfe_pkg.sv
package bfe_pkg;

   localparam int MUL_W      = 23;
   localparam int QUOT_BITS  = 15;
   localparam int STEP_W     = 4;
   localparam int CSR_IDX_W  = 3;
   localparam int OP_W       = 3;
   localparam int NUM_OPS    = 5;

   localparam logic [CSR_IDX_W-1:0] CSR_MOMENTUM_GAIN = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TREND_GAIN    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_GAIN    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_OFFSET  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_VOLUME_GAIN   = 3'd4;

   localparam logic [15:0] MOMENTUM_GAIN_RST = 16'd5120;
   localparam logic [15:0] TREND_GAIN_RST    = 16'd7680;
   localparam logic [15:0] RANGE_GAIN_RST    = 16'd10240;
   localparam logic [15:0] RANGE_OFFSET_RST  = 16'd1311;
   localparam logic [15:0] VOLUME_GAIN_RST   = 16'd128;

   localparam logic [OP_W-1:0] OP_MOMENTUM = 3'd0;
   localparam logic [OP_W-1:0] OP_TREND    = 3'd1;
   localparam logic [OP_W-1:0] OP_RANGE    = 3'd2;
   localparam logic [OP_W-1:0] OP_VOLUME   = 3'd3;
   localparam logic [OP_W-1:0] OP_INTRADAY = 3'd4;

   typedef struct packed {
      logic        new_series;
      logic [31:0] open_price;
      logic [31:0] high_price;
      logic [31:0] low_price;
      logic [31:0] close_price;
      logic [31:0] bar_volume;
   } req_type;

   typedef struct packed {
      logic               features_valid;
      logic signed [15:0] momentum_feature;
      logic signed [15:0] trend_feature;
      logic signed [15:0] range_feature;
      logic signed [15:0] volume_feature;
      logic signed [15:0] intraday_return;
   } rsp_type;

   typedef struct packed {
      logic            accept;
      logic            issue;
      logic            store;
      logic            commit;
      logic [OP_W-1:0] op;
   } cmd_type;

   typedef struct packed {
      logic div_done;
   } sts_type;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_ISSUE  = 4'b0010,
      ST_WAIT   = 4'b0100,
      ST_FINISH = 4'b1000
   } ctrl_state_type;

   typedef enum logic [4:0] {
      DIV_IDLE   = 5'b00001,
      DIV_MUL_LO = 5'b00010,
      DIV_MUL_HI = 5'b00100,
      DIV_CHECK  = 5'b01000,
      DIV_STEP   = 5'b10000
   } div_state_type;

endpackage

FILE: rtl/core/bfe_div.sv
module bfe_div #(
   parameter int NW = 49,
   parameter int DW = 44
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [NW-1:0]                 num,
   input  logic [bfe_pkg::MUL_W-1:0]     mul,
   input  logic [DW-1:0]                 den,
   input  logic                          neg,
   output logic                          done,
   output logic signed [15:0]            quot
);

   localparam int MW = bfe_pkg::MUL_W;
   localparam int H  = (NW + 1) / 2;
   localparam int PW = NW + MW;
   localparam int RW = ((PW > DW + bfe_pkg::QUOT_BITS) ? PW : DW + bfe_pkg::QUOT_BITS) + 1;

   bfe_pkg::div_state_type state_ff, state_in;
   logic                  done_ff, done_in;
   logic [NW-1:0]         n_ff, n_in;
   logic [MW-1:0]         m_ff, m_in;
   logic [DW-1:0]         d_ff, d_in;
   logic                  neg_ff, neg_in;
   logic                  sat_ff, sat_in;
   logic [RW-1:0]         acc_ff, acc_in;
   logic [RW-1:0]         dsh_ff, dsh_in;
   logic [bfe_pkg::QUOT_BITS-1:0] q_ff, q_in;
   logic [bfe_pkg::STEP_W-1:0]    cnt_ff, cnt_in;

   logic [H+MW-1:0]       prod_lo;
   logic [NW-H+MW-1:0]    prod_hi;
   logic [RW-1:0]         d_top;
   logic [15:0]           mag;

   assign prod_lo = (H+MW)'(n_ff[H-1:0]) * (H+MW)'(m_ff);
   assign prod_hi = (NW-H+MW)'(n_ff[NW-1:H]) * (NW-H+MW)'(m_ff);
   assign d_top   = RW'(d_ff) << bfe_pkg::QUOT_BITS;

   always_comb begin
      state_in = state_ff;
      done_in  = 1'b0;
      n_in     = n_ff;
      m_in     = m_ff;
      d_in     = d_ff;
      neg_in   = neg_ff;
      sat_in   = sat_ff;
      acc_in   = acc_ff;
      dsh_in   = dsh_ff;
      q_in     = q_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         bfe_pkg::DIV_IDLE: begin
            if (start) begin
               n_in     = num;
               m_in     = mul;
               d_in     = den;
               neg_in   = neg;
               state_in = bfe_pkg::DIV_MUL_LO;
            end
         end
         bfe_pkg::DIV_MUL_LO: begin
            acc_in   = RW'(prod_lo);
            state_in = bfe_pkg::DIV_MUL_HI;
         end
         bfe_pkg::DIV_MUL_HI: begin
            acc_in   = acc_ff + (RW'(prod_hi) << H);
            state_in = bfe_pkg::DIV_CHECK;
         end
         bfe_pkg::DIV_CHECK: begin
            // quotient of 2^15 or more always saturates
            if (acc_ff >= d_top) begin
               sat_in   = 1'b1;
               done_in  = 1'b1;
               state_in = bfe_pkg::DIV_IDLE;
            end else begin
               sat_in   = 1'b0;
               q_in     = '0;
               dsh_in   = RW'(d_ff) << (bfe_pkg::QUOT_BITS - 1);
               cnt_in   = bfe_pkg::STEP_W'(bfe_pkg::QUOT_BITS - 1);
               state_in = bfe_pkg::DIV_STEP;
            end
         end
         bfe_pkg::DIV_STEP: begin
            if (acc_ff >= dsh_ff) begin
               acc_in = acc_ff - dsh_ff;
               q_in   = {q_ff[bfe_pkg::QUOT_BITS-2:0], 1'b1};
            end else begin
               q_in   = {q_ff[bfe_pkg::QUOT_BITS-2:0], 1'b0};
            end
            dsh_in = dsh_ff >> 1;
            if (cnt_ff == '0) begin
               done_in  = 1'b1;
               state_in = bfe_pkg::DIV_IDLE;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         default: state_in = bfe_pkg::DIV_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bfe_pkg::DIV_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      n_ff   <= n_in;
      m_ff   <= m_in;
      d_ff   <= d_in;
      neg_ff <= neg_in;
      sat_ff <= sat_in;
      acc_ff <= acc_in;
      dsh_ff <= dsh_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
   end

   always_comb begin
      if (sat_ff) mag = neg_ff ? 16'h8000 : 16'h7fff;
      else        mag = {1'b0, q_ff};
   end

   assign done = done_ff;
   assign quot = neg_ff ? (16'd0 - mag) : mag;

endmodule

FILE: rtl/core/bfe_ctrl.sv
module bfe_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   input  bfe_pkg::sts_type sts,
   output bfe_pkg::cmd_type cmd
);

   bfe_pkg::ctrl_state_type      state_ff, state_in;
   logic [bfe_pkg::OP_W-1:0]     op_ff, op_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         out_free;

   // output register can take a new result this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      cmd        = '0;
      cmd.op     = op_ff;
      unique case (state_ff)
         bfe_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               op_in      = bfe_pkg::OP_MOMENTUM;
               state_in   = bfe_pkg::ST_ISSUE;
            end
         end
         bfe_pkg::ST_ISSUE: begin
            cmd.issue = 1'b1;
            state_in  = bfe_pkg::ST_WAIT;
         end
         bfe_pkg::ST_WAIT: begin
            if (sts.div_done) begin
               cmd.store = 1'b1;
               if (op_ff == bfe_pkg::OP_W'(bfe_pkg::NUM_OPS - 1)) begin
                  state_in = bfe_pkg::ST_FINISH;
               end else begin
                  op_in    = op_ff + 1'b1;
                  state_in = bfe_pkg::ST_ISSUE;
               end
            end
         end
         bfe_pkg::ST_FINISH: begin
            if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = bfe_pkg::ST_IDLE;
            end
         end
         default: state_in = bfe_pkg::ST_IDLE;
      endcase
   end

   assign rsp_valid_in = cmd.commit || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bfe_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff <= op_in;
   end

   assign req_stall = (state_ff != bfe_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: rtl/core/bfe_datapath.sv
module bfe_datapath #(
   parameter int LONG_WINDOW  = 20,
   parameter int SHORT_WINDOW = 5,
   parameter int PRICE_WIDTH  = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  bfe_pkg::req_type                req_data,
   output bfe_pkg::rsp_type                rsp_data,
   input  logic                            csr_write,
   input  logic [bfe_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [15:0]                     csr_data,
   input  bfe_pkg::cmd_type                cmd,
   output bfe_pkg::sts_type                sts
);

   localparam int PB     = (PRICE_WIDTH < 32) ? PRICE_WIDTH : 32;
   localparam int NB     = (LONG_WINDOW > SHORT_WINDOW) ? LONG_WINDOW : SHORT_WINDOW;
   localparam int SWB    = $clog2(SHORT_WINDOW + 1);
   localparam int LWB    = $clog2(LONG_WINDOW + 1);
   localparam int SUMS_W = PB + SWB;
   localparam int SUML_W = PB + LWB;
   localparam int TW     = PB + SWB + LWB;
   localparam int RGW    = PB + 17;
   localparam int VW     = 32 + SWB;
   localparam int NW_A   = (TW > RGW) ? TW : RGW;
   localparam int NW     = (NW_A > VW) ? NW_A : VW;
   localparam int DW_A   = (TW > PB + 9) ? TW : PB + 9;
   localparam int DW     = (DW_A > VW) ? DW_A : VW;
   localparam int CNT_W  = $clog2(NB + 1);
   localparam int SIDX   = (SHORT_WINDOW >= 2) ? SHORT_WINDOW - 2 : 0;
   localparam int MW     = bfe_pkg::MUL_W;

   logic [15:0] mom_gain_ff, trend_gain_ff, range_gain_ff, range_off_ff, vol_gain_ff;

   bfe_pkg::req_type bar_ff;
   bfe_pkg::rsp_type rsp_ff;
   logic [PB-1:0]     chist_ff [NB];
   logic [31:0]       vhist_ff [SHORT_WINDOW];
   logic [SUMS_W-1:0] sum_s_ff;
   logic [SUML_W-1:0] sum_l_ff;
   logic [VW-1:0]     sum_v_ff;
   logic [CNT_W-1:0]  seen_ff;
   logic signed [15:0] feat_ff [bfe_pkg::NUM_OPS];

   logic [PB-1:0] o, h, l, c, gc, go, gh0, h0, drop_s;
   logic [31:0]   v;
   logic          valid;

   logic [SUMS_W-1:0] sum_s;
   logic [SUML_W-1:0] sum_l;
   logic [TW-1:0]     a_t, b_t, d_t;
   logic [PB+15:0]    a_r, b_r;
   logic [VW-1:0]     a_v, b_v;

   logic [NW-1:0] op_n;
   logic [MW-1:0] op_m;
   logic [DW-1:0] op_d;
   logic          op_neg;

   logic          div_done;
   logic signed [15:0] div_q;

   assign o  = bar_ff.open_price[PB-1:0];
   assign h  = bar_ff.high_price[PB-1:0];
   assign l  = bar_ff.low_price[PB-1:0];
   assign c  = bar_ff.close_price[PB-1:0];
   assign v  = bar_ff.bar_volume;
   assign h0 = chist_ff[0];

   // a zero price as divisor counts as one
   assign gc  = (c == '0) ? PB'(1) : c;
   assign go  = (o == '0) ? PB'(1) : o;
   assign gh0 = (h0 == '0) ? PB'(1) : h0;

   assign valid  = (seen_ff >= CNT_W'(NB));
   assign drop_s = (SHORT_WINDOW >= 2) ? chist_ff[SIDX] : c;

   assign sum_s = SUMS_W'(c) + sum_s_ff;
   assign sum_l = SUML_W'(c) + sum_l_ff;
   assign a_t   = TW'(LONG_WINDOW) * TW'(sum_s);
   assign b_t   = TW'(SHORT_WINDOW) * TW'(sum_l);
   assign d_t   = TW'(SHORT_WINDOW * LONG_WINDOW) * TW'(gc);
   assign a_r   = {h - l, 16'd0};
   assign b_r   = (PB+16)'(range_off_ff) * (PB+16)'(gc);
   assign a_v   = VW'(SHORT_WINDOW) * VW'(v);
   assign b_v   = sum_v_ff + VW'(SHORT_WINDOW);

   always_comb begin
      op_n   = '0;
      op_m   = '0;
      op_d   = DW'(1);
      op_neg = 1'b0;
      case (cmd.op)
         bfe_pkg::OP_MOMENTUM: begin
            op_neg = (c < h0);
            op_n   = op_neg ? NW'(h0 - c) : NW'(c - h0);
            op_m   = {mom_gain_ff, 7'd0};
            op_d   = DW'(gh0);
         end
         bfe_pkg::OP_TREND: begin
            op_neg = (a_t < b_t);
            op_n   = op_neg ? NW'(b_t - a_t) : NW'(a_t - b_t);
            op_m   = {trend_gain_ff, 7'd0};
            op_d   = DW'(d_t);
         end
         bfe_pkg::OP_RANGE: begin
            if (h >= l) begin
               op_neg = (a_r < b_r);
               op_n   = op_neg ? NW'(b_r - a_r) : NW'(a_r - b_r);
            end else begin
               // high below low: negative range plus offset
               op_neg = 1'b1;
               op_n   = NW'(RGW'({l - h, 16'd0}) + RGW'(b_r));
            end
            op_m = MW'(range_gain_ff);
            op_d = DW'({gc, 9'd0});
         end
         bfe_pkg::OP_VOLUME: begin
            op_neg = (a_v < b_v);
            op_n   = op_neg ? NW'(b_v - a_v) : NW'(a_v - b_v);
            op_m   = {vol_gain_ff, 7'd0};
            op_d   = DW'(b_v);
         end
         bfe_pkg::OP_INTRADAY: begin
            op_neg = (c < o);
            op_n   = op_neg ? NW'(o - c) : NW'(c - o);
            op_m   = MW'(32768);
            op_d   = DW'(go);
         end
         default: op_n = '0;
      endcase
   end

   bfe_div #(
      .NW(NW),
      .DW(DW)
   ) u_div (
      .clock(clock),
      .reset(reset),
      .start(cmd.issue),
      .num  (op_n),
      .mul  (op_m),
      .den  (op_d),
      .neg  (op_neg),
      .done (div_done),
      .quot (div_q)
   );

   assign sts.div_done = div_done;

   always_ff @(posedge clock) begin
      if (reset) begin
         mom_gain_ff   <= bfe_pkg::MOMENTUM_GAIN_RST;
         trend_gain_ff <= bfe_pkg::TREND_GAIN_RST;
         range_gain_ff <= bfe_pkg::RANGE_GAIN_RST;
         range_off_ff  <= bfe_pkg::RANGE_OFFSET_RST;
         vol_gain_ff   <= bfe_pkg::VOLUME_GAIN_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            bfe_pkg::CSR_MOMENTUM_GAIN: mom_gain_ff   <= csr_data;
            bfe_pkg::CSR_TREND_GAIN:    trend_gain_ff <= csr_data;
            bfe_pkg::CSR_RANGE_GAIN:    range_gain_ff <= csr_data;
            bfe_pkg::CSR_RANGE_OFFSET:  range_off_ff  <= csr_data;
            bfe_pkg::CSR_VOLUME_GAIN:   vol_gain_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // history and running sums, cleared by reset or a new series
   always_ff @(posedge clock) begin
      if (reset || (cmd.accept && req_data.new_series)) begin
         for (int i = 0; i < NB; i++) chist_ff[i] <= '0;
         for (int i = 0; i < SHORT_WINDOW; i++) vhist_ff[i] <= '0;
         sum_s_ff <= '0;
         sum_l_ff <= '0;
         sum_v_ff <= '0;
         seen_ff  <= '0;
      end else if (cmd.commit) begin
         for (int i = NB - 1; i > 0; i--) chist_ff[i] <= chist_ff[i-1];
         chist_ff[0] <= c;
         for (int i = SHORT_WINDOW - 1; i > 0; i--) vhist_ff[i] <= vhist_ff[i-1];
         vhist_ff[0] <= v;
         sum_s_ff <= sum_s_ff + SUMS_W'(c) - SUMS_W'(drop_s);
         sum_l_ff <= sum_l_ff + SUML_W'(c) - SUML_W'(chist_ff[LONG_WINDOW-2]);
         sum_v_ff <= sum_v_ff + VW'(v) - VW'(vhist_ff[SHORT_WINDOW-1]);
         if (!valid) seen_ff <= seen_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) bar_ff <= req_data;
      if (cmd.store) begin
         case (cmd.op)
            bfe_pkg::OP_MOMENTUM: feat_ff[0] <= div_q;
            bfe_pkg::OP_TREND:    feat_ff[1] <= div_q;
            bfe_pkg::OP_RANGE:    feat_ff[2] <= div_q;
            bfe_pkg::OP_VOLUME:   feat_ff[3] <= div_q;
            bfe_pkg::OP_INTRADAY: feat_ff[4] <= div_q;
            default: ;
         endcase
      end
      if (cmd.commit) begin
         rsp_ff.features_valid   <= valid;
         rsp_ff.momentum_feature <= valid ? feat_ff[0] : 16'sd0;
         rsp_ff.trend_feature    <= valid ? feat_ff[1] : 16'sd0;
         rsp_ff.range_feature    <= valid ? feat_ff[2] : 16'sd0;
         rsp_ff.volume_feature   <= valid ? feat_ff[3] : 16'sd0;
         rsp_ff.intraday_return  <= feat_ff[4];
      end
   end

   assign rsp_data = rsp_ff;

endmodule

FILE: rtl/core/bar_feature_extractor_top.sv
// Bar feature extractor: takes one instrument's OHLCV bars and returns one result
// per bar with momentum, trend, range and volume features (Q1.15, zero until
// LONG_WINDOW earlier bars are held) plus the bar's intraday return. Bars are
// processed one at a time; each bar runs five divisions in turn on one shared
// multiply-divide unit (a low and a high multiply step, one saturation check and
// fifteen restoring steps). A division whose quotient saturates skips the restoring
// steps. Once all five are stored, the result is registered as soon as the output
// register is free, and the input opens again as it appears. A finished result
// waits in an output register while the next bar is taken; the input stays stalled
// once the following result is done and the earlier one has still not been taken.
module bar_feature_extractor_top #(
   parameter int LONG_WINDOW  = 20,
   parameter int SHORT_WINDOW = 5,
   parameter int PRICE_WIDTH  = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  bfe_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output bfe_pkg::rsp_type              rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [bfe_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]                   csr_data
);

   bfe_pkg::cmd_type cmd;
   bfe_pkg::sts_type sts;
   logic             csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   bfe_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .sts      (sts),
      .cmd      (cmd)
   );

   bfe_datapath #(
      .LONG_WINDOW (LONG_WINDOW),
      .SHORT_WINDOW(SHORT_WINDOW),
      .PRICE_WIDTH (PRICE_WIDTH)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .rsp_data (rsp_data),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_data (csr_data),
      .cmd      (cmd),
      .sts      (sts)
   );

endmodule

FILE: rtl/core/bfe_checker.sv
module bfe_assertions (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input bfe_pkg::req_type              req_data,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input bfe_pkg::rsp_type              rsp_data,
   input logic                          csr_valid,
   input logic                          csr_ready,
   input logic [bfe_pkg::CSR_IDX_W-1:0] csr_index,
   input logic [15:0]                   csr_data
);

   // a bar runs five divisions, so the input closes right after a transfer
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input not stalled after transfer");

   // features are zero while history is short
   a_zero_when_invalid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.features_valid |->
         rsp_data.momentum_feature == 16'sd0 && rsp_data.trend_feature == 16'sd0 &&
         rsp_data.range_feature == 16'sd0 && rsp_data.volume_feature == 16'sd0)
      else $error("features nonzero without valid history");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_data))
      else $error("result changed while stalled");

endmodule

bind bar_feature_extractor_top bfe_assertions u_bfe_checker (
   .clock    (clock),
   .reset    (reset),
   .req_valid(req_valid),
   .req_stall(req_stall),
   .req_data (req_data),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_data (rsp_data),
   .csr_valid(csr_valid),
   .csr_ready(csr_ready),
   .csr_index(csr_index),
   .csr_data (csr_data)
);

FILE: verif/bfe_checker.sv
module bfe_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  bfe_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  bfe_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   input  logic             csr_ready,
   input  logic [bfe_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]      csr_data,
   output int               fail_count,
   output int               pending_count
);

   localparam int LONG_W  = 20;
   localparam int SHORT_W = 5;

   logic [31:0] closes [LONG_W];
   logic [31:0] volumes [SHORT_W];
   int          held_bars;
   logic [15:0] mom_gain, trd_gain, rng_gain, rng_off, vol_gain;
   bfe_pkg::rsp_type feature_fifo [$];

   // floor(n*m/d) clipped to cap
   function automatic logic [15:0] scaled_quot(logic [127:0] n, logic [127:0] m,
                                               logic [127:0] d, logic [127:0] cap);
      logic [127:0] q;
      q = (n * m) / d;
      return (q > cap) ? cap[15:0] : q[15:0];
   endfunction

   function automatic logic [15:0] q15_of(bit neg, logic [127:0] n, logic [127:0] m,
                                          logic [127:0] d);
      logic [15:0] mag;
      mag = scaled_quot(n, m, d, neg ? 128'd32768 : 128'd32767);
      return neg ? 16'(17'h10000 - mag) : mag;
   endfunction

   function automatic logic [15:0] diff_ratio(logic [127:0] a, logic [127:0] b,
                                              logic [127:0] m, logic [127:0] d);
      return (a < b) ? q15_of(1, b - a, m, d) : q15_of(0, a - b, m, d);
   endfunction

   function automatic logic [127:0] nz(logic [127:0] p);
      return (p == 0) ? 128'd1 : p;
   endfunction

   task automatic predict_bar(bfe_pkg::req_type r);
      bfe_pkg::rsp_type e;
      logic [127:0] o, h, l, c, v, gc, ss, sl, sv;
      o = r.open_price; h = r.high_price; l = r.low_price;
      c = r.close_price; v = r.bar_volume;
      if (r.new_series) begin
         foreach (closes[k]) closes[k] = 0;
         foreach (volumes[k]) volumes[k] = 0;
         held_bars = 0;
      end
      gc = nz(c);
      e = '0;
      if (held_bars >= LONG_W) begin
         e.features_valid = 1'b1;
         e.momentum_feature = diff_ratio(c, closes[0], mom_gain * 128, nz(closes[0]));
         ss = c; sl = c; sv = 0;
         for (int k = 0; k < SHORT_W - 1; k++) ss += closes[k];
         for (int k = 0; k < LONG_W - 1; k++) sl += closes[k];
         e.trend_feature = diff_ratio(LONG_W * ss, SHORT_W * sl, trd_gain * 128,
                                      SHORT_W * LONG_W * gc);
         if (h >= l)
            e.range_feature = diff_ratio((h - l) << 16, rng_off * gc, rng_gain, 512 * gc);
         else
            e.range_feature = q15_of(1, ((l - h) << 16) + rng_off * gc, rng_gain,
                                     512 * gc);
         for (int k = 0; k < SHORT_W; k++) sv += volumes[k];
         e.volume_feature = diff_ratio(SHORT_W * v, sv + SHORT_W, vol_gain * 128,
                                       sv + SHORT_W);
      end
      e.intraday_return = diff_ratio(c, o, 32768, nz(o));
      for (int k = LONG_W - 1; k > 0; k--) closes[k] = closes[k-1];
      closes[0] = r.close_price;
      for (int k = SHORT_W - 1; k > 0; k--) volumes[k] = volumes[k-1];
      volumes[0] = r.bar_volume;
      if (held_bars < LONG_W) held_bars++;
      feature_fifo = {feature_fifo, e};
   endtask

   task automatic note_mismatch(string what, bfe_pkg::rsp_type e, bfe_pkg::rsp_type a);
      fail_count++;
      if (fail_count <= 10)
         $display("mismatch %s: expected %h actual %h", what, e, a);
   endtask

   always @(posedge clock) begin
      bfe_pkg::rsp_type e;
      if (reset) begin
         foreach (closes[k]) closes[k] <= 0;
         foreach (volumes[k]) volumes[k] <= 0;
         held_bars <= 0;
         mom_gain <= bfe_pkg::MOMENTUM_GAIN_RST;
         trd_gain <= bfe_pkg::TREND_GAIN_RST;
         rng_gain <= bfe_pkg::RANGE_GAIN_RST;
         rng_off  <= bfe_pkg::RANGE_OFFSET_RST;
         vol_gain <= bfe_pkg::VOLUME_GAIN_RST;
         fail_count <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               bfe_pkg::CSR_MOMENTUM_GAIN: mom_gain = csr_data;
               bfe_pkg::CSR_TREND_GAIN:    trd_gain = csr_data;
               bfe_pkg::CSR_RANGE_GAIN:    rng_gain = csr_data;
               bfe_pkg::CSR_RANGE_OFFSET:  rng_off  = csr_data;
               bfe_pkg::CSR_VOLUME_GAIN:   vol_gain = csr_data;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (feature_fifo.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) $display("unexpected transfer %h", rsp_data);
            end else begin
               e = feature_fifo.pop_front();
               if (rsp_data.features_valid !== e.features_valid)
                  note_mismatch("features_valid", e, rsp_data);
               else if (rsp_data.momentum_feature !== e.momentum_feature)
                  note_mismatch("momentum_feature", e, rsp_data);
               else if (rsp_data.trend_feature !== e.trend_feature)
                  note_mismatch("trend_feature", e, rsp_data);
               else if (rsp_data.range_feature !== e.range_feature)
                  note_mismatch("range_feature", e, rsp_data);
               else if (rsp_data.volume_feature !== e.volume_feature)
                  note_mismatch("volume_feature", e, rsp_data);
               else if (rsp_data.intraday_return !== e.intraday_return)
                  note_mismatch("intraday_return", e, rsp_data);
            end
         end
         if (req_valid && !req_stall) predict_bar(req_data);
      end
      pending_count = feature_fifo.size();
   end
endmodule

FILE: verif/tb_bar_feature_extractor_top.sv
module tb_bar_feature_extractor_top;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   bfe_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   bfe_pkg::rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [bfe_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [15:0] csr_data = '0;
   int fail_count, pending_count;
   int cycle_count = 0;
   int stall_left = 0;
   bit hold_rsp = 1'b0;
   logic [31:0] walk_close = 32'd100000;

   always #1 clock = ~clock;

   bar_feature_extractor_top dut (.*);

   bfe_checker checker_i (.*);

   function automatic int gap_len();
      return ($urandom_range(0, 19) == 0) ? $urandom_range(20, 150) : $urandom_range(0, 3);
   endfunction

   function automatic logic [31:0] any_word();
      case ($urandom_range(0, 3))
         0: return $urandom();
         1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
         2: return $urandom_range(0, 3);
         default: return 32'(1) << $urandom_range(0, 31);
      endcase
   endfunction

   // mostly a realistic random walk, sometimes raw extremes
   function automatic bfe_pkg::req_type make_bar(bit fresh);
      bfe_pkg::req_type r;
      logic [31:0] base;
      r.new_series = fresh;
      if ($urandom_range(0, 9) == 0) begin
         r.open_price = any_word(); r.high_price = any_word();
         r.low_price = any_word(); r.close_price = any_word();
         r.bar_volume = any_word();
      end else begin
         base = walk_close;
         walk_close = base + $urandom_range(0, 4000) - 2000;
         if (walk_close < 1000) walk_close = 100000;
         r.open_price = base;
         r.close_price = walk_close;
         r.high_price = ((base > walk_close) ? base : walk_close) + $urandom_range(0, 1500);
         r.low_price = ((base < walk_close) ? base : walk_close) - $urandom_range(0, 1500);
         r.bar_volume = $urandom_range(0, 1000000);
      end
      return r;
   endfunction

   task automatic send_bar(bfe_pkg::req_type r);
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      while (pending_count != 0) @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   task automatic write_reg(logic [bfe_pkg::CSR_IDX_W-1:0] idx, logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_gains(logic [15:0] m, logic [15:0] t, logic [15:0] g,
                              logic [15:0] o, logic [15:0] v);
      write_reg(bfe_pkg::CSR_MOMENTUM_GAIN, m);
      write_reg(bfe_pkg::CSR_TREND_GAIN, t);
      write_reg(bfe_pkg::CSR_RANGE_GAIN, g);
      write_reg(bfe_pkg::CSR_RANGE_OFFSET, o);
      write_reg(bfe_pkg::CSR_VOLUME_GAIN, v);
   endtask

   // receiver stalls of random length; one long hold-off comes from the stimulus side
   always @(posedge clock) begin
      if (hold_rsp) begin
         rsp_stall <= 1'b1;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
         stall_left <= gap_len();
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 3000000) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      bfe_pkg::req_type r;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: special cases with defaults
      r = '0; r.new_series = 1'b1; send_bar(r);                    // zero prices
      r = '1; send_bar(r);                                         // all ones, clears
      r = '0; r.open_price = 32'd1000; r.close_price = 32'd2000;
      r.high_price = 32'd900; r.low_price = 32'd1500; r.bar_volume = '1;
      send_bar(r);                                                 // high below low
      for (int k = 0; k < 22; k++) send_bar(make_bar(k == 0));
      wait_drained();
      write_gains(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      for (int k = 0; k < 150; k++) begin
         send_bar(make_bar(k == 0 || $urandom_range(0, 60) == 0));
         repeat (gap_len()) @(posedge clock);
      end
      wait_drained();
      write_gains(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
      for (int k = 0; k < 60; k++) send_bar(make_bar(k == 0));
      wait_drained();
      write_gains(16'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom()),
                  16'($urandom()));
      // long receiver hold-off while bars keep coming
      fork
         begin
            hold_rsp = 1'b1;
            repeat (2000) @(posedge clock);
            hold_rsp = 1'b0;
         end
         for (int k = 0; k < 20; k++) send_bar(make_bar(k == 0));
      join
      wait_drained();
      write_gains(bfe_pkg::MOMENTUM_GAIN_RST, bfe_pkg::TREND_GAIN_RST,
                  bfe_pkg::RANGE_GAIN_RST, bfe_pkg::RANGE_OFFSET_RST,
                  bfe_pkg::VOLUME_GAIN_RST);
      for (int k = 0; k < 300; k++) begin
         send_bar(make_bar(k == 0 || $urandom_range(0, 80) == 0));
         repeat (gap_len()) @(posedge clock);
      end
      wait_drained();
      if (fail_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end
endmodule
